@@ rtl/sidta_pkg.sv @@
// Shared constants and types for the signed integer to decimal text converter.
package sidta_pkg;

    // Width of the incoming two's complement integer.
    localparam int VALUE_W = 32;
    // Number of decimal digit cells; ten digits hold any 32-bit magnitude.
    localparam int NUM_DIGITS = 10;
    // Width of one binary coded decimal digit.
    localparam int DIGIT_W = 4;
    // Counter widths.
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);
    // Width of one output character.
    localparam int CHAR_W = 6;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Control word that the sequencer hands to every digit cell.
    typedef struct packed {
        logic clear;       // load zero into the digit
        logic bit_shift;   // one double-dabble step: adjust, then shift in a bit
        logic digit_shift; // take the digit of the lower neighbour
    } cell_ctl_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

@@ rtl/sidta_digit_cell.sv @@
// One decimal digit cell of the binary to decimal shift chain.
module sidta_digit_cell
(
    input  logic                          clk,
    input  sidta_pkg::cell_ctl_t          ctl,
    input  logic                          bit_in,
    input  logic [sidta_pkg::DIGIT_W-1:0] digit_in,
    output logic                          carry_out,
    output logic [sidta_pkg::DIGIT_W-1:0] digit
);

    logic [sidta_pkg::DIGIT_W-1:0] digit_reg;
    logic [sidta_pkg::DIGIT_W-1:0] digit_next;
    logic [sidta_pkg::DIGIT_W-1:0] adjusted;

    // A digit of five or more would overflow when doubled, so add three first.
    assign adjusted  = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adjusted[sidta_pkg::DIGIT_W-1];

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.bit_shift)
        begin
            digit_next = {adjusted[sidta_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctl.digit_shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: converts a signed 32-bit integer into its decimal text, one character per word.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-----------------------
//  value   | in        | value_valid / value_stall | value[31:0] signed
//  char    | out       | char_valid / char_stall   | ascii_char[5:0], last_char
//
// Sequence: an accepted item runs through thirty-two bit-serial double-dabble steps
// through the ten digit cells, one magnitude bit a cycle; then leading zeros are
// dropped, the zero-skipping step is left, the minus sign (for a negative value)
// and the digit characters are sent while char_stall allows, and the sequencer
// returns to idle, where the next word is taken.
// Reset clears the sequencer and the output valid flag; the digit cells hold no
// control state and are cleared when a word is accepted.
// A stalled output holds its word; the sequencer waits in its emit state meanwhile.
// The next input word is taken as soon as the last character sits in the output
// register, so it may be accepted while that character still waits to be taken.
module signed_int_to_decimal_ascii
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 value_valid,
    output logic                                 value_stall,
    input  logic signed [sidta_pkg::VALUE_W-1:0] value,
    output logic                                 char_valid,
    input  logic                                 char_stall,
    output logic        [sidta_pkg::CHAR_W-1:0]  ascii_char,
    output logic                                 last_char
);

    localparam int NUM_DIGITS = sidta_pkg::NUM_DIGITS;
    localparam int DIGIT_W    = sidta_pkg::DIGIT_W;

    // Sequencer state.
    sidta_pkg::state_t state_reg;
    sidta_pkg::state_t state_next;

    // The magnitude is shifted out most significant bit first into the cell chain.
    logic [sidta_pkg::VALUE_W-1:0]   mag_reg;
    logic [sidta_pkg::VALUE_W-1:0]   mag_next;
    logic [sidta_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [sidta_pkg::BIT_CNT_W-1:0] bit_cnt_next;
    // Number of digits still to be sent (or skipped), counting from the top cell.
    logic [sidta_pkg::DIG_CNT_W-1:0] dig_cnt_reg;
    logic [sidta_pkg::DIG_CNT_W-1:0] dig_cnt_next;
    // A minus sign is still owed for the current number.
    logic                            sign_reg;
    logic                            sign_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [sidta_pkg::CHAR_W-1:0]  out_char_reg;
    logic [sidta_pkg::CHAR_W-1:0]  out_char_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    logic                          accept;
    logic                          out_free;
    logic [sidta_pkg::VALUE_W-1:0] value_u;

    sidta_pkg::cell_ctl_t cell_ctl;
    logic [DIGIT_W-1:0]   digit [NUM_DIGITS];
    logic                 carry [NUM_DIGITS];
    logic [DIGIT_W-1:0]   top_digit;

    assign value_stall = (state_reg != sidta_pkg::S_IDLE);
    assign accept      = value_valid && !value_stall;
    assign out_free    = !out_valid_reg || !char_stall;
    assign value_u     = value;
    assign top_digit   = digit[NUM_DIGITS-1];

    // The chain of digit cells. Cell zero takes the next magnitude bit and a zero
    // digit; every other cell takes the carry and the digit of the cell below it.
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sidta_digit_cell u_cell
            (
                .clk       (clk),
                .ctl       (cell_ctl),
                .bit_in    (mag_reg[sidta_pkg::VALUE_W-1]),
                .digit_in  ({DIGIT_W{1'b0}}),
                .carry_out (carry[i]),
                .digit     (digit[i])
            );
        end
        else
        begin : g_rest
            sidta_digit_cell u_cell
            (
                .clk       (clk),
                .ctl       (cell_ctl),
                .bit_in    (carry[i-1]),
                .digit_in  (digit[i-1]),
                .carry_out (carry[i]),
                .digit     (digit[i])
            );
        end
    end

    // Sequencer: convert, drop leading zeros, then send the sign and the digits.
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_next      = sign_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && char_stall;
        cell_ctl       = '0;

        case (state_reg)
            sidta_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // Negating in unsigned arithmetic gives the right magnitude
                    // for the most negative integer as well.
                    mag_next       = value_u[sidta_pkg::VALUE_W-1] ? ('0 - value_u) : value_u;
                    sign_next      = value_u[sidta_pkg::VALUE_W-1];
                    bit_cnt_next   = '0;
                    cell_ctl.clear = 1'b1;
                    state_next     = sidta_pkg::S_CONV;
                end
            end
            sidta_pkg::S_CONV:
            begin
                cell_ctl.bit_shift = 1'b1;
                mag_next           = {mag_reg[sidta_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next       = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sidta_pkg::BIT_CNT_W'(sidta_pkg::VALUE_W - 1))
                begin
                    dig_cnt_next = sidta_pkg::DIG_CNT_W'(NUM_DIGITS);
                    state_next   = sidta_pkg::S_SKIP;
                end
            end
            sidta_pkg::S_SKIP:
            begin
                // Zero itself keeps its one digit.
                if ((top_digit == '0) && (dig_cnt_reg > sidta_pkg::DIG_CNT_W'(1)))
                begin
                    cell_ctl.digit_shift = 1'b1;
                    dig_cnt_next         = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = sidta_pkg::S_EMIT;
                end
            end
            sidta_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = sidta_pkg::CHAR_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next        = sidta_pkg::CHAR_ZERO
                                               + sidta_pkg::CHAR_W'(top_digit);
                        out_last_next        = (dig_cnt_reg == sidta_pkg::DIG_CNT_W'(1));
                        cell_ctl.digit_shift = 1'b1;
                        dig_cnt_next         = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == sidta_pkg::DIG_CNT_W'(1))
                        begin
                            state_next = sidta_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sidta_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sidta_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        sign_reg     <= sign_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign char_valid = out_valid_reg;
    assign ascii_char = out_char_reg;
    assign last_char  = out_last_reg;

endmodule

@@ rtl/sidta_checker.sv @@
// Port-level checker for the decimal text converter, with its bind to the top level.
module sidta_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         value_valid,
    input logic                         value_stall,
    input logic                         char_valid,
    input logic                         char_stall,
    input logic [sidta_pkg::CHAR_W-1:0] ascii_char,
    input logic                         last_char
);

    // A stalled output word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(ascii_char) && $stable(last_char))
    else $error("output word changed while stalled");

    // Only a minus sign or a decimal digit ever leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (ascii_char == sidta_pkg::CHAR_MINUS)
                    || ((ascii_char >= sidta_pkg::CHAR_ZERO)
                        && (ascii_char <= sidta_pkg::CHAR_ZERO + 6'd9)))
    else $error("character outside the minus sign and digits");

    // A minus sign is never the final character of a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (ascii_char == sidta_pkg::CHAR_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

    // Once a word is taken the converter is busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
    else $error("input taken while conversion starts");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .ascii_char  (ascii_char),
    .last_char   (last_char)
);
